/* src/tlfla_pkg.sv */
// ----------------------------------------------------------------------------
// tlfla_pkg - shared types and constants of the two-level slot allocator
// Field widths, status and mode codes, and the command and status groups
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tlfla_pkg;

  localparam int MODE_W  = 1;
  localparam int BLK_W   = 3;
  localparam int SLOT_W  = 7;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 11;

  localparam int DEF_SLOTS_PER_BLOCK = 128;
  localparam int DEF_NUM_BLOCKS      = 8;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  typedef struct packed {
    logic accept;           // input transfer, issue first reads
    logic sweep;            // initialisation pass after reset
    logic alloc_read_link;  // read link of the head slot
    logic alloc_commit;     // write back an allocation, load result
    logic free_commit;      // first write set of a free, load result
    logic free_finish;      // second write of a free
    logic emit_empty;       // load an empty-pool result
    logic emit_reject;      // load a rejected-free result
  } tlfla_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic alloc_fail;
    logic free_fail;
    logic out_free;
  } tlfla_stat_t;

endpackage

/* src/tlfla_ram.sv */
// ----------------------------------------------------------------------------
// tlfla_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data; read data
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module tlfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/tlfla_ctrl.sv */
// ----------------------------------------------------------------------------
// tlfla_ctrl - request sequencer of the slot allocator
// Runs the initialisation pass, then steps each request through its read
// and write-back cycles, holding the state that loads the result while the result is stalled.
// ----------------------------------------------------------------------------
module tlfla_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [tlfla_pkg::MODE_W-1:0] in_mode,
  output logic                     in_ready,
  input  tlfla_pkg::tlfla_stat_t   stat,
  output tlfla_pkg::tlfla_cmd_t    cmd
);

  import tlfla_pkg::*;

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_A1    = 3'd2;
  localparam logic [2:0] S_A2    = 3'd3;
  localparam logic [2:0] S_F1    = 3'd4;
  localparam logic [2:0] S_F2    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_mode == MODE_FREE) ? S_F1 : S_A1;
        end
      end
      S_A1: begin
        if (stat.alloc_fail) begin
          if (stat.out_free) begin
            cmd.emit_empty = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.alloc_read_link = 1'b1;
          state_nxt           = S_A2;
        end
      end
      S_A2: begin
        if (stat.out_free) begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_F1: begin
        if (stat.out_free) begin
          if (stat.free_fail) begin
            cmd.emit_reject = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.free_commit = 1'b1;
            state_nxt       = S_F2;
          end
        end
      end
      S_F2: begin
        cmd.free_finish = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.sweep, cmd.alloc_read_link, cmd.alloc_commit,
              cmd.free_commit, cmd.free_finish, cmd.emit_empty, cmd.emit_reject}))
    else $error("controller issued more than one command");

  a_finish_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.free_finish |-> $past(cmd.free_commit))
    else $error("free finish without a preceding free commit");

endmodule

/* src/tlfla_dp.sv */
// ----------------------------------------------------------------------------
// tlfla_dp - datapath of the slot allocator
// Slot link memory with allocated flags, block table and block link
// memories, block queue pointers, pool count and the result register.
// ----------------------------------------------------------------------------
module tlfla_dp #(
  parameter int NUM_BLOCKS      = tlfla_pkg::DEF_NUM_BLOCKS,
  parameter int SLOTS_PER_BLOCK = tlfla_pkg::DEF_SLOTS_PER_BLOCK
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tlfla_pkg::tlfla_cmd_t         cmd,
  output tlfla_pkg::tlfla_stat_t        stat,
  input  logic [tlfla_pkg::MODE_W-1:0]  in_mode,
  input  logic [tlfla_pkg::BLK_W-1:0]   in_block_index,
  input  logic [tlfla_pkg::SLOT_W-1:0]  in_slot_index,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tlfla_pkg::STAT_W-1:0]  out_status,
  output logic [tlfla_pkg::BLK_W-1:0]   out_granted_block,
  output logic [tlfla_pkg::SLOT_W-1:0]  out_granted_slot,
  output logic [tlfla_pkg::TOTAL_W-1:0] out_free_total
);

  import tlfla_pkg::*;

  localparam int SW    = $clog2(SLOTS_PER_BLOCK);
  localparam int BW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LW    = $clog2(SLOTS_PER_BLOCK + 1);
  localparam int NLW   = $clog2(NUM_BLOCKS + 1);
  localparam int AW    = BW + SW;
  localparam int TOTAL = NUM_BLOCKS * SLOTS_PER_BLOCK;
  localparam int PW    = $clog2(TOTAL + 1);
  localparam int BTW   = 3 * LW;

  localparam logic [LW-1:0]  LINK_NULL = LW'(SLOTS_PER_BLOCK);
  localparam logic [NLW-1:0] BLK_NULL  = NLW'(NUM_BLOCKS);

  logic [NLW-1:0] qh_r, qh_nxt;
  logic [NLW-1:0] qt_r, qt_nxt;
  logic [PW-1:0]  pool_r, pool_nxt;
  logic [AW-1:0]  sweep_r;
  logic [BW-1:0]  blk_r;
  logic [SW-1:0]  slot_r;
  logic           range_bad_r;

  logic           out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [BLK_W-1:0]   out_block_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [TOTAL_W-1:0] out_total_r;

  logic           lk_we, lk_re;
  logic [AW-1:0]  lk_waddr, lk_raddr;
  logic [LW:0]    lk_wdata, lk_q;
  logic           bt_we;
  logic [BW-1:0]  bt_waddr, bt_raddr;
  logic [BTW-1:0] bt_wdata, bt_q;
  logic           bn_we;
  logic [BW-1:0]  bn_waddr;
  logic [NLW-1:0] bn_wdata, bn_q;

  logic [LW-1:0]  bt_head, bt_tail, bt_count, cnt_dec;
  logic [LW-1:0]  lk_next;
  logic           lk_alloc;
  logic [BW-1:0]  in_blk;
  logic [SW-1:0]  in_slot;
  logic           head_case;
  logic           out_load;

  assign {bt_head, bt_tail, bt_count} = bt_q;
  assign {lk_alloc, lk_next}          = lk_q;
  assign cnt_dec   = bt_count - LW'(1);
  assign in_blk    = BW'(in_block_index);
  assign in_slot   = SW'(in_slot_index);
  assign head_case = (bt_count == '0) || (bt_tail >= LINK_NULL);

  tlfla_ram #(.WIDTH(LW + 1), .DEPTH(2 ** AW)) u_link_ram (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .re(lk_re), .raddr(lk_raddr), .rdata(lk_q)
  );

  tlfla_ram #(.WIDTH(BTW), .DEPTH(2 ** BW)) u_btab_ram (
    .clk(clk), .we(bt_we), .waddr(bt_waddr), .wdata(bt_wdata),
    .re(cmd.accept), .raddr(bt_raddr), .rdata(bt_q)
  );

  tlfla_ram #(.WIDTH(NLW), .DEPTH(2 ** BW)) u_bnext_ram (
    .clk(clk), .we(bn_we), .waddr(bn_waddr), .wdata(bn_wdata),
    .re(cmd.accept), .raddr(qh_r[BW-1:0]), .rdata(bn_q)
  );

  // read ports
  always_comb begin
    lk_re    = (cmd.accept && (in_mode == MODE_FREE)) || cmd.alloc_read_link;
    lk_raddr = cmd.alloc_read_link ? {qh_r[BW-1:0], bt_head[SW-1:0]} : {in_blk, in_slot};
    bt_raddr = (in_mode == MODE_FREE) ? in_blk : qh_r[BW-1:0];
  end

  // write ports
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = sweep_r;
    lk_wdata = {1'b0, LW'(sweep_r[SW-1:0]) + LW'(1)};
    bt_we    = 1'b0;
    bt_waddr = sweep_r[BW-1:0];
    bt_wdata = {LW'(0), LW'(SLOTS_PER_BLOCK - 1), LW'(SLOTS_PER_BLOCK)};
    bn_we    = 1'b0;
    bn_waddr = sweep_r[BW-1:0];
    bn_wdata = NLW'(sweep_r[BW-1:0]) + NLW'(1);
    priority if (cmd.sweep) begin
      lk_we = 1'b1;
      bt_we = 1'b1;
      bn_we = 1'b1;
    end else if (cmd.alloc_commit) begin
      lk_we    = 1'b1;
      lk_waddr = {blk_r, bt_head[SW-1:0]};
      lk_wdata = {1'b1, LINK_NULL};
      bt_we    = 1'b1;
      bt_waddr = blk_r;
      bt_wdata = (cnt_dec == '0) ? {LINK_NULL, LINK_NULL, LW'(0)}
                                 : {lk_next, bt_tail, cnt_dec};
      bn_we    = (cnt_dec == '0);
      bn_waddr = blk_r;
      bn_wdata = BLK_NULL;
    end else if (cmd.free_commit) begin
      lk_we    = 1'b1;
      lk_waddr = {blk_r, slot_r};
      lk_wdata = {1'b0, LINK_NULL};
      bt_we    = 1'b1;
      bt_waddr = blk_r;
      bt_wdata = {head_case ? LW'(slot_r) : bt_head, LW'(slot_r), bt_count + LW'(1)};
      bn_we    = (bt_count == '0) && (pool_r != '0) && (qt_r < BLK_NULL);
      bn_waddr = qt_r[BW-1:0];
      bn_wdata = NLW'(blk_r);
    end else if (cmd.free_finish) begin
      lk_we    = !head_case;
      lk_waddr = {blk_r, bt_tail[SW-1:0]};
      lk_wdata = {1'b0, LW'(slot_r)};
      bn_we    = (bt_count == '0);
      bn_waddr = blk_r;
      bn_wdata = BLK_NULL;
    end else begin
      lk_we = 1'b0;
    end
  end

  // queue pointers and pool count
  always_comb begin
    qh_nxt   = qh_r;
    qt_nxt   = qt_r;
    pool_nxt = pool_r;
    if (cmd.alloc_commit) begin
      pool_nxt = pool_r - PW'(1);
      if (cnt_dec == '0) begin
        qh_nxt = bn_q;
        if (pool_r == PW'(1)) begin
          qh_nxt = BLK_NULL;
          qt_nxt = BLK_NULL;
        end
      end
    end else if (cmd.free_commit) begin
      pool_nxt = pool_r + PW'(1);
      if (bt_count == '0) begin
        if ((pool_r == '0) || (qt_r >= BLK_NULL)) begin
          qh_nxt = NLW'(blk_r);
        end
        qt_nxt = NLW'(blk_r);
      end
    end
  end

  assign out_load = cmd.alloc_commit || cmd.free_commit || cmd.emit_empty || cmd.emit_reject;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qh_r        <= '0;
      qt_r        <= NLW'(NUM_BLOCKS - 1);
      pool_r      <= PW'(TOTAL);
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      qh_r   <= qh_nxt;
      qt_r   <= qt_nxt;
      pool_r <= pool_nxt;
      if (cmd.sweep) begin
        sweep_r <= sweep_r + AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      blk_r       <= (in_mode == MODE_FREE) ? in_blk : qh_r[BW-1:0];
      slot_r      <= in_slot;
      range_bad_r <= (32'(in_block_index) >= 32'(NUM_BLOCKS)) ||
                     (32'(in_slot_index) >= 32'(SLOTS_PER_BLOCK));
    end
    if (out_load) begin
      out_total_r <= TOTAL_W'(pool_nxt);
      priority if (cmd.alloc_commit) begin
        out_status_r <= ST_OK;
        out_block_r  <= BLK_W'(blk_r);
        out_slot_r   <= SLOT_W'(bt_head);
      end else if (cmd.free_commit) begin
        out_status_r <= ST_OK;
        out_block_r  <= '0;
        out_slot_r   <= '0;
      end else if (cmd.emit_empty) begin
        out_status_r <= ST_EMPTY;
        out_block_r  <= '0;
        out_slot_r   <= '0;
      end else begin
        out_status_r <= ST_REJECT;
        out_block_r  <= '0;
        out_slot_r   <= '0;
      end
    end
  end

  always_comb begin
    stat.sweep_done = (sweep_r == '1);
    stat.alloc_fail = (pool_r == '0) || (qh_r >= BLK_NULL) ||
                      (bt_count == '0) || (bt_head >= LINK_NULL);
    stat.free_fail  = range_bad_r || !lk_alloc;
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_block_r;
  assign out_granted_slot  = out_slot_r;
  assign out_free_total    = out_total_r;

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pool_r <= PW'(TOTAL))
    else $error("pool count above pool size");

  a_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pool_r == '0) == (qh_r == BLK_NULL))
    else $error("block queue and pool count disagree");

  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_commit |=> out_valid_r && (out_status_r == ST_OK))
    else $error("allocation did not load an ok result");

endmodule

/* src/two_level_free_list_allocator_unit.sv */
// ----------------------------------------------------------------------------
// two_level_free_list_allocator_unit - two-level free-list slot allocator
// Hands out and takes back slots of a pool of blocks, each block a FIFO of
// free slots, the blocks that hold free slots a FIFO of blocks.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/ready): in_mode 0 allocates,
// in_mode 1 frees the slot named by in_block_index and in_slot_index.
// Every request returns exactly one result on the out_ channel: a status,
// the granted handle for an allocation, and the pool's free count.
// An allocation issues its block table read on transfer and its slot link read
// in state A1, then writes back and loads its result in A2; a free loads its
// result in F1 and then does one more write in F2. So one request is in
// flight and a new one is taken only once the block is back in idle. An
// empty-pool allocation or a rejected free loads its result in A1 or F1.
// An allocation needs two dependent reads (block table, then slot link) before
// its write-back; a free writes the slot link memory and the block link memory
// twice through their single write ports.
// After reset the block runs an initialisation pass over the slot link
// memory, all 2**(clog2(NUM_BLOCKS)+clog2(SLOTS_PER_BLOCK)) addresses (1024 by
// default), with in_ready low. A result waits in an output register; a new
// request is still taken while it waits, then holds in its write-back cycle
// until the receiver takes the waiting result.
// ----------------------------------------------------------------------------
module two_level_free_list_allocator_unit #(
  parameter int NUM_BLOCKS      = tlfla_pkg::DEF_NUM_BLOCKS,
  parameter int SLOTS_PER_BLOCK = tlfla_pkg::DEF_SLOTS_PER_BLOCK
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tlfla_pkg::MODE_W-1:0]  in_mode,
  input  logic [tlfla_pkg::BLK_W-1:0]   in_block_index,
  input  logic [tlfla_pkg::SLOT_W-1:0]  in_slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tlfla_pkg::STAT_W-1:0]  out_status,
  output logic [tlfla_pkg::BLK_W-1:0]   out_granted_block,
  output logic [tlfla_pkg::SLOT_W-1:0]  out_granted_slot,
  output logic [tlfla_pkg::TOTAL_W-1:0] out_free_total
);

  import tlfla_pkg::*;

  tlfla_cmd_t  cmd;
  tlfla_stat_t stat;

  tlfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlfla_dp #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_block_index    (in_block_index),
    .in_slot_index     (in_slot_index),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_granted_slot  (out_granted_slot),
    .out_free_total    (out_free_total)
  );

endmodule

/* test/two_level_free_list_allocator_unit_tb.sv */
// ----------------------------------------------------------------------------
// two_level_free_list_allocator_unit_tb - self-checking bench of the allocator
// A short table of directed requests, then random allocate/free traffic that
// drains the pool to empty, churns it near empty and adds stray frees. A
// shadow allocator predicts each result that the table does not fix. Sender
// bursts, receiver stall patterns and one long receiver hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module two_level_free_list_allocator_unit_tb;
  import tlfla_pkg::*;

  localparam int NB       = DEF_NUM_BLOCKS;
  localparam int SPB      = DEF_SLOTS_PER_BLOCK;
  localparam int RX_OPEN    = 0;
  localparam int RX_COIN    = 1;
  localparam int RX_PATTERN = 2;
  localparam int HOLD_AT  = 2500;
  localparam int HOLD_LEN = 400;
  localparam int DIR_ROWS = 12;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [BLK_W-1:0]   blk;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] total;
  } grant_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BLK_W-1:0]  blk;
    logic [SLOT_W-1:0] slot;
    logic              fixed;
    grant_t            res;
  } dir_row_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode        = MODE_ALLOC;
  logic [BLK_W-1:0]    in_block_index = '0;
  logic [SLOT_W-1:0]   in_slot_index  = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [BLK_W-1:0]    out_granted_block;
  logic [SLOT_W-1:0]   out_granted_slot;
  logic [TOTAL_W-1:0]  out_free_total;

  two_level_free_list_allocator_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_block_index    (in_block_index),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_granted_slot  (out_granted_slot),
    .out_free_total    (out_free_total)
  );

  always #5 clk = ~clk;

  // shadow allocator
  logic [7:0]         sh_link [NB][SPB];
  logic [7:0]         sh_head [NB];
  logic [7:0]         sh_tail [NB];
  logic [7:0]         sh_count [NB];
  logic [3:0]         sh_next [NB];
  logic [3:0]         sh_qhead;
  logic [3:0]         sh_qtail;
  logic [TOTAL_W-1:0] sh_pool;
  bit                 sh_used [NB][SPB];

  grant_t                   grant_q [$];
  logic [BLK_W+SLOT_W-1:0]  held_q [$];
  int                       err_cnt     = 0;
  int                       burst_left  = 0;
  grant_t                   seen, want;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{MODE_ALLOC, 3'd0, 7'd0,   1'b1, '{ST_OK,     3'd0, 7'd0, 11'd1023}},
    '{MODE_ALLOC, 3'd0, 7'd0,   1'b1, '{ST_OK,     3'd0, 7'd1, 11'd1022}},
    '{MODE_FREE,  3'd0, 7'd0,   1'b1, '{ST_OK,     3'd0, 7'd0, 11'd1023}},
    '{MODE_FREE,  3'd0, 7'd0,   1'b1, '{ST_REJECT, 3'd0, 7'd0, 11'd1023}},
    '{MODE_FREE,  3'd7, 7'd127, 1'b1, '{ST_REJECT, 3'd0, 7'd0, 11'd1023}},
    '{MODE_FREE,  3'd0, 7'd127, 1'b1, '{ST_REJECT, 3'd0, 7'd0, 11'd1023}},
    '{MODE_ALLOC, 3'd0, 7'd0,   1'b1, '{ST_OK,     3'd0, 7'd2, 11'd1022}},
    '{MODE_FREE,  3'd0, 7'd1,   1'b0, '{ST_OK,     3'd0, 7'd0, 11'd0}},
    '{MODE_FREE,  3'd0, 7'd2,   1'b1, '{ST_OK,     3'd0, 7'd0, 11'd1024}},
    '{MODE_FREE,  3'd3, 7'd64,  1'b1, '{ST_REJECT, 3'd0, 7'd0, 11'd1024}},
    '{MODE_ALLOC, 3'd7, 7'd127, 1'b1, '{ST_OK,     3'd0, 7'd3, 11'd1023}},
    '{MODE_FREE,  3'd0, 7'd3,   1'b0, '{ST_OK,     3'd0, 7'd0, 11'd0}}
  };

  task automatic shadow_reset();
    for (int b = 0; b < NB; b++) begin
      for (int s = 0; s < SPB; s++) begin
        sh_link[b][s] = 8'(s + 1);
        sh_used[b][s] = 1'b0;
      end
      sh_head[b]  = '0;
      sh_tail[b]  = 8'(SPB - 1);
      sh_count[b] = 8'(SPB);
      sh_next[b]  = 4'(b + 1);
    end
    sh_qhead = '0;
    sh_qtail = 4'(NB - 1);
    sh_pool  = TOTAL_W'(NB * SPB);
  endtask

  task automatic shadow_request(input logic [MODE_W-1:0] m, input logic [BLK_W-1:0] bi,
                                input logic [SLOT_W-1:0] si, output grant_t g);
    int b, s, t, nx;
    g.blk  = '0;
    g.slot = '0;
    if (m == MODE_ALLOC) begin
      b = sh_qhead;
      g.status = ST_EMPTY;
      if (sh_pool != 0 && b < NB && sh_count[b] != 0 && sh_head[b] < SPB) begin
        s  = sh_head[b];
        nx = sh_link[b][s];
        sh_link[b][s] = 8'(SPB);
        sh_used[b][s] = 1'b1;
        sh_count[b]--;
        sh_pool--;
        if (sh_count[b] == 0) begin
          sh_head[b] = 8'(SPB);
          sh_tail[b] = 8'(SPB);
          sh_qhead   = sh_next[b];
          sh_next[b] = 4'(NB);
          if (sh_pool == 0) begin
            sh_qhead = 4'(NB);
            sh_qtail = 4'(NB);
          end
        end else begin
          sh_head[b] = 8'(nx);
        end
        g.status = ST_OK;
        g.blk    = BLK_W'(b);
        g.slot   = SLOT_W'(s);
        held_q.push_back({g.blk, g.slot});
      end
    end else begin
      b = bi;
      s = si;
      g.status = ST_REJECT;
      if (b < NB && s < SPB && sh_used[b][s]) begin
        sh_used[b][s] = 1'b0;
        sh_link[b][s] = 8'(SPB);
        t = sh_tail[b];
        if (sh_count[b] == 0 || t >= SPB) sh_head[b] = 8'(s);
        else sh_link[b][t] = 8'(s);
        sh_tail[b] = 8'(s);
        sh_count[b]++;
        if (sh_count[b] == 1) begin
          if (sh_pool == 0 || sh_qtail >= NB) sh_qhead = 4'(b);
          else sh_next[sh_qtail] = 4'(b);
          sh_qtail   = 4'(b);
          sh_next[b] = 4'(NB);
        end
        sh_pool++;
        g.status = ST_OK;
      end
    end
    g.total = sh_pool;
  endtask

  // offer one request, wait for its transfer, record the expected grant
  task automatic send_request(input logic [MODE_W-1:0] m, input logic [BLK_W-1:0] b,
                              input logic [SLOT_W-1:0] s, input bit fixed,
                              input grant_t fixed_res);
    grant_t g;
    int     gap;
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_block_index <= b;
    in_slot_index  <= s;
    do @(posedge clk); while (!in_ready);
    shadow_request(m, b, s, g);
    grant_q.push_back(fixed ? fixed_res : g);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic free_held();
    int                      k;
    logic [BLK_W+SLOT_W-1:0] h;
    k = $urandom_range(0, held_q.size() - 1);
    h = held_q[k];
    held_q[k] = held_q[held_q.size() - 1];
    held_q.pop_back();
    send_request(MODE_FREE, h[BLK_W+SLOT_W-1:SLOT_W], h[SLOT_W-1:0], 1'b0, '0);
  endtask

  task automatic send_random(input logic [MODE_W-1:0] m);
    send_request(m, BLK_W'($urandom), SLOT_W'($urandom), 1'b0, '0);
  endtask

  // receiver
  initial begin
    int cyc, seg_mode, seg_left, hold_left;
    cyc = 0;
    seg_mode = RX_OPEN;
    seg_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_AT) hold_left = HOLD_LEN;
      if (seg_left == 0) begin
        seg_mode = $urandom_range(RX_OPEN, RX_PATTERN);
        seg_left = $urandom_range(20, 120);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (seg_mode)
          RX_OPEN:  out_ready <= 1'b1;
          RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
          default:  out_ready <= ((cyc % 5) < 3);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_status, out_granted_block, out_granted_slot, out_free_total};
      if (grant_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: result with no pending request: st=%0d blk=%0d slot=%0d total=%0d",
                   $realtime, seen.status, seen.blk, seen.slot, seen.total);
      end else begin
        want = grant_q.pop_front();
        if (seen !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: mismatch: exp st=%0d blk=%0d slot=%0d total=%0d, got st=%0d blk=%0d slot=%0d total=%0d",
                     $realtime, want.status, want.blk, want.slot, want.total,
                     seen.status, seen.blk, seen.slot, seen.total);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("** two_level_free_list_allocator_unit: FAILED **");
    $finish;
  end

  initial begin
    shadow_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_request(dir_tab[i].mode, dir_tab[i].blk, dir_tab[i].slot,
                   dir_tab[i].fixed, dir_tab[i].res);
    held_q.delete();

    // mixed traffic with stray frees
    repeat (200) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 50 || held_q.size() == 0) send_random(MODE_ALLOC);
      else if (r < 90) free_held();
      else send_random(MODE_FREE);
    end

    // drain to empty, then allocate from an empty pool
    while (sh_pool != 0) begin
      if ($urandom_range(0, 99) < 5 && held_q.size() != 0) free_held();
      else send_random(MODE_ALLOC);
    end
    repeat (3) send_random(MODE_ALLOC);

    // churn near empty as blocks rejoin the queue
    repeat (350) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) send_random(MODE_FREE);
      else if (r < 65 && held_q.size() != 0) free_held();
      else send_random(MODE_ALLOC);
    end

    repeat (120) send_random(MODE_W'($urandom_range(0, 1)));

    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_cnt == 0)
      $display("** two_level_free_list_allocator_unit: PASSED **");
    else
      $display("** two_level_free_list_allocator_unit: FAILED **");
    $finish;
  end

endmodule
